FILE: rtl/crsf_pkg.sv
package crsf_pkg;

    // frame layout and protocol constants
    localparam logic [7:0] RC_TYPE    = 8'h16;
    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] HEAD_LEN   = 8'd5;
    localparam logic [7:0] PAYLOAD_AT = 8'd3;
    localparam logic [7:0] CRC_AT     = 8'd22;
    localparam int         CH_BITS    = 11;

    localparam logic [23:0] GAP_LIMIT_RESET = 24'd1100;

    // result status codes
    localparam logic [1:0] ST_CHANNEL    = 2'd0;
    localparam logic [1:0] ST_CRC_ERR    = 2'd1;
    localparam logic [1:0] ST_OTHER_TYPE = 2'd2;
    localparam logic [1:0] ST_OVERSIZE   = 2'd3;

    // access request from the sequencer to the frame store
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_addr;
    } store_req_t;

    // one byte through the crc-8 shift register, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/crsf_frame_receiver_top.sv
// Frame receiver for the serial RC link: assembles frames from received bytes
// and unpacks the channels of an RC-channels frame.
// Input stream: one transaction per received byte. tdata carries the byte and
// the tick gap since the previous byte, tuser the receiver overrun flag.
// Output stream: one transaction per result. A good RC frame gives one result
// per channel, index 0 upward, tlast on the final one; any other completed
// frame gives a single status result with tlast set.
// cfg_we/cfg_wdata load the gap limit; write it only while the block is idle.
// s_axis_tready is low while each received byte is stored, so a further byte
// is not taken until that store step is done. A completed non-RC or oversize
// frame goes through the done and status steps before its result is registered.
// An RC frame with length byte L reads its L-2 stored payload bytes in turn
// through the single store read port, a read and a crc step each, then the crc
// byte for the check. Unpacking takes a read and an accumulate step per packed
// byte and emits each buffered channel while the output is free.
// When the output stalls, the sequencer waits on the result register; the
// input stays not ready until the whole frame's results are loaded.
// Reset clears the frame position, the store contents (read as zero) and the
// output valid flag, and loads the gap limit with 1100 ticks.
module crsf_frame_receiver_top #(
    parameter int STORE_BYTES = 64,
    parameter int CHANNELS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,      // gap_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // rx_byte[7:0], gap_ticks[31:8]
    input  logic        s_axis_tuser,   // overrun
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // frame_type[7:0], channel_index[11:8],
                                        // channel_value[22:12], zero[23]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last
);

    import crsf_pkg::*;

    logic [23:0] gap_limit_reg;
    store_req_t  store_req;
    logic [7:0]  store_rd_data;

    // gap limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= GAP_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            gap_limit_reg <= cfg_wdata;
        end
    end

    crsf_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (store_rd_data)
    );

    crsf_ctrl #(
        .STORE_BYTES (STORE_BYTES),
        .CHANNELS    (CHANNELS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .gap_limit     (gap_limit_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .store_req     (store_req),
        .store_rd_data (store_rd_data)
    );

endmodule

FILE: rtl/crsf_ram.sv
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/crsf_store.sv
module crsf_store #(
    parameter int STORE_BYTES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crsf_pkg::store_req_t req,
    output logic [7:0]           rd_data
);

    import crsf_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [STORE_BYTES-1:0] valid_reg;
    logic                   rd_hit_reg;
    logic                   wr_in_range;
    logic                   rd_in_range;
    logic [7:0]             ram_q;

    // positions past the store are never written and read as zero
    assign wr_in_range = {1'b0, req.wr_addr} < 9'(STORE_BYTES);
    assign rd_in_range = {1'b0, req.rd_addr} < 9'(STORE_BYTES);

    crsf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en && wr_in_range),
        .wr_addr (req.wr_addr[AW-1:0]),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr[AW-1:0]),
        .rd_data (ram_q)
    );

    // per-entry valid bits give the all-zero reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en && wr_in_range)
            begin
                valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= rd_in_range && valid_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_data = rd_hit_reg ? ram_q : 8'd0;

endmodule

FILE: rtl/crsf_ctrl.sv
module crsf_ctrl #(
    parameter int STORE_BYTES = 64,
    parameter int CHANNELS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [23:0]          gap_limit,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast,
    output crsf_pkg::store_req_t store_req,
    input  logic [7:0]           store_rd_data
);

    import crsf_pkg::*;

    localparam int BUF_W = CH_BITS + 7;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_STORE   = 4'd1;
    localparam logic [3:0] S_DONE    = 4'd2;
    localparam logic [3:0] S_CRC_RD  = 4'd3;
    localparam logic [3:0] S_CRC_ACC = 4'd4;
    localparam logic [3:0] S_CHECK   = 4'd5;
    localparam logic [3:0] S_UNP     = 4'd6;
    localparam logic [3:0] S_UNP_ACC = 4'd7;
    localparam logic [3:0] S_STAT    = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [7:0]       byte_reg, byte_next;
    logic             restart_reg, restart_next;
    logic [7:0]       write_pos_reg, write_pos_next;
    logic             oversize_reg, oversize_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       idx_reg, idx_next;
    logic [BUF_W-1:0] bits_reg, bits_next;
    logic [4:0]       bitcnt_reg, bitcnt_next;
    logic [3:0]       chan_reg, chan_next;
    logic [1:0]       status_reg, status_next;

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [7:0]       m_type_reg;
    logic [3:0]       m_index_reg;
    logic [10:0]      m_value_reg;
    logic             m_last_reg;

    logic             out_free;
    logic             emit;
    logic [1:0]       emit_status;
    logic [3:0]       emit_index;
    logic [10:0]      emit_value;
    logic             emit_last;

    logic [7:0]       wp;
    logic [7:0]       wp_inc;
    logic [7:0]       expect_len;
    logic             wp_in_store;
    logic [7:0]       n_bytes;
    logic             chan_is_last;

    // position arithmetic for the byte being stored
    assign wp          = restart_reg ? 8'd0 : write_pos_reg;
    assign wp_inc      = wp + 8'd1;
    assign expect_len  = (wp < 8'd3) ? HEAD_LEN : (len_reg + 8'd2);
    assign wp_in_store = {1'b0, wp} < 9'(STORE_BYTES);
    assign n_bytes     = (len_reg >= 8'd2) ? (len_reg - 8'd2) : 8'd0;
    assign chan_is_last = (chan_reg == 4'(CHANNELS - 1));

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        restart_next   = restart_reg;
        write_pos_next = write_pos_reg;
        oversize_next  = oversize_reg;
        len_next       = len_reg;
        type_next      = type_reg;
        crc_next       = crc_reg;
        idx_next       = idx_reg;
        bits_next      = bits_reg;
        bitcnt_next    = bitcnt_reg;
        chan_next      = chan_reg;
        status_next    = status_reg;

        store_req.wr_en   = 1'b0;
        store_req.wr_addr = wp;
        store_req.wr_data = byte_reg;
        store_req.rd_en   = 1'b0;
        store_req.rd_addr = PAYLOAD_AT + idx_reg;

        emit        = 1'b0;
        emit_status = ST_CHANNEL;
        emit_index  = 4'd0;
        emit_value  = 11'd0;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    byte_next    = s_axis_tdata[7:0];
                    restart_next = s_axis_tuser || (s_axis_tdata[31:8] > gap_limit);
                    state_next   = S_STORE;
                end
            end
            S_STORE:
            begin
                if (wp >= expect_len)
                begin
                    // frame already full, byte dropped
                    write_pos_next = wp;
                    state_next     = S_IDLE;
                end
                else
                begin
                    store_req.wr_en = 1'b1;
                    oversize_next   = ((wp == 8'd0) ? 1'b0 : oversize_reg) | !wp_in_store;
                    if (wp == 8'd1)
                    begin
                        len_next = byte_reg;
                    end
                    if (wp == 8'd2)
                    begin
                        type_next = byte_reg;
                    end
                    if (wp_inc < expect_len)
                    begin
                        write_pos_next = wp_inc;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        write_pos_next = 8'd0;
                        state_next     = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (oversize_reg)
                begin
                    status_next = ST_OVERSIZE;
                    state_next  = S_STAT;
                end
                else if (type_reg != RC_TYPE)
                begin
                    status_next = ST_OTHER_TYPE;
                    state_next  = S_STAT;
                end
                else
                begin
                    // type byte is known here, so its crc is a constant
                    crc_next   = crc8_step(8'd0, RC_TYPE);
                    idx_next   = 8'd0;
                    state_next = S_CRC_RD;
                end
            end
            S_CRC_RD:
            begin
                store_req.rd_en = 1'b1;
                if (idx_reg < n_bytes)
                begin
                    state_next = S_CRC_ACC;
                end
                else
                begin
                    store_req.rd_addr = PAYLOAD_AT + CRC_AT;
                    state_next        = S_CHECK;
                end
            end
            S_CRC_ACC:
            begin
                crc_next   = crc8_step(crc_reg, store_rd_data);
                idx_next   = idx_reg + 8'd1;
                state_next = S_CRC_RD;
            end
            S_CHECK:
            begin
                if (crc_reg != store_rd_data)
                begin
                    status_next = ST_CRC_ERR;
                    state_next  = S_STAT;
                end
                else
                begin
                    bits_next   = '0;
                    bitcnt_next = 5'd0;
                    chan_next   = 4'd0;
                    idx_next    = 8'd0;
                    state_next  = S_UNP;
                end
            end
            S_UNP:
            begin
                if (bitcnt_reg >= 5'(CH_BITS))
                begin
                    // a whole channel is buffered
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_CHANNEL;
                        emit_index  = chan_reg;
                        emit_value  = bits_reg[CH_BITS-1:0];
                        emit_last   = chan_is_last;
                        bits_next   = bits_reg >> CH_BITS;
                        bitcnt_next = bitcnt_reg - 5'(CH_BITS);
                        chan_next   = chan_reg + 4'd1;
                        if (chan_is_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    store_req.rd_en = 1'b1;
                    state_next      = S_UNP_ACC;
                end
            end
            S_UNP_ACC:
            begin
                bits_next   = bits_reg | (BUF_W'(store_rd_data) << bitcnt_reg);
                bitcnt_next = bitcnt_reg + 5'd8;
                idx_next    = idx_reg + 8'd1;
                state_next  = S_UNP;
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = status_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            restart_reg   <= 1'b0;
            write_pos_reg <= 8'd0;
            oversize_reg  <= 1'b0;
            len_reg       <= 8'd0;
            type_reg      <= 8'd0;
            bitcnt_reg    <= 5'd0;
            chan_reg      <= 4'd0;
            idx_reg       <= 8'd0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            restart_reg   <= restart_next;
            write_pos_reg <= write_pos_next;
            oversize_reg  <= oversize_next;
            len_reg       <= len_next;
            type_reg      <= type_next;
            bitcnt_reg    <= bitcnt_next;
            chan_reg      <= chan_next;
            idx_reg       <= idx_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        crc_reg    <= crc_next;
        bits_reg   <= bits_next;
        status_reg <= status_next;
        if (emit)
        begin
            m_status_reg <= emit_status;
            m_type_reg   <= type_reg;
            m_index_reg  <= emit_index;
            m_value_reg  <= emit_value;
            m_last_reg   <= emit_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {1'b0, m_value_reg, m_index_reg, m_type_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_accept_to_store: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_STORE)
        else $error("accepted transaction did not enter store step");

    a_done_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> write_pos_reg == 8'd0)
        else $error("write position not cleared at frame completion");

    a_read_then_use: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.rd_en |=> (state_reg == S_CRC_ACC || state_reg == S_CHECK ||
                             state_reg == S_UNP_ACC))
        else $error("store read issued without a consuming step");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STAT && out_free |=> m_valid_reg && m_last_reg &&
                                          state_reg == S_IDLE)
        else $error("status result not delivered as final transaction");

    a_bitcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bitcnt_reg <= 5'(BUF_W))
        else $error("channel bit buffer overfilled");
`endif

endmodule

FILE: test/crsf_frame_receiver_top_tb.sv
`timescale 1ns / 100ps

module crsf_frame_receiver_top_tb;

    import crsf_pkg::*;

    localparam int STORE_BYTES     = 64;
    localparam int CHANNELS        = 16;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int BYTES_PER_PHASE = 50;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLDOFF_CYCLES  = 400;

    // where a directed byte takes its expected results from
    typedef enum logic {BY_MODEL, BY_TABLE} row_check_e;

    // kinds of generated byte sequences
    typedef enum int {FR_RC_GOOD, FR_RC_BAD_CRC, FR_RC_ODD_LEN, FR_OTHER, FR_OVERSIZE,
                      FR_NOISE} frame_kind_e;

    // one received byte, with the expected result where the table gives it
    typedef struct packed {
        logic [7:0]  rx;
        logic [23:0] gap;
        logic        ovr;
        row_check_e  chk;
        logic        yields;
        logic [1:0]  st;
        logic [7:0]  ty;
    } rx_row_t;

    // one decoded result
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  ftype;
        logic [3:0]  idx;
        logic [10:0] val;
        logic        last;
    } rc_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [23:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;      // rx_byte[7:0], gap_ticks[31:8]
    logic        s_axis_tuser;      // overrun
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;      // frame_type[7:0], channel_index[11:8],
                                    // channel_value[22:12], zero[23]
    logic [1:0]  m_axis_tuser;      // status[1:0]
    logic        m_axis_tlast;

    // predictor state
    logic [7:0]  frame_mem [STORE_BYTES];
    logic [7:0]  frame_pos;
    logic        frame_big;
    logic [23:0] gap_lim;

    rc_result_t  byte_results[$];
    rc_result_t  pending_results[$];

    int          err_count;
    int          bytes_in;
    int          results_seen;
    int          tx_calm;
    int          rx_calm;
    int          rx_hold;
    bit          quiet;
    bit          holdoff_done;

    // directed bytes, gap limit at its reset value of 1100
    rx_row_t dir_rows [24] = '{
        '{8'hC8, 24'hFFFFFF, 1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h03, 24'h000000, 1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h28, 24'd1100,   1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h00, 24'h000005, 1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        '{8'hFF, 24'h000000, 1'b0, BY_TABLE, 1'b1, ST_OTHER_TYPE, 8'h28},
        // length byte of zero, then bytes past the frame end
        '{8'h00, 24'h000000, 1'b1, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h00, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h16, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'hAA, 24'h000000, 1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h55, 24'd1000,   1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        // gap just over the limit restarts, short rc frame
        '{8'hC8, 24'd1101,   1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h03, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h16, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h12, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h34, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        // length byte that wraps to zero
        '{8'hEE, 24'h000000, 1'b1, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'hFE, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h16, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h77, 24'h000000, 1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        // length byte that wraps to one
        '{8'hEE, 24'h000000, 1'b1, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'hFF, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h00, 24'h000000, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h11, 24'h000000, 1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00},
        '{8'h16, 24'h000000, 1'b0, BY_TABLE, 1'b0, ST_CHANNEL,    8'h00}
    };

    crsf_frame_receiver_top #(
        .STORE_BYTES (STORE_BYTES),
        .CHANNELS    (CHANNELS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // crc-8 over one byte, polynomial 0xd5
    function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        repeat (8)
        begin
            c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // stored byte, zero past the store
    function automatic logic [7:0] mem_rd(input int unsigned a);
        if (a < STORE_BYTES)
            return frame_mem[a];
        return 8'h00;
    endfunction

    // frame assembly and decode for one received byte; results go to byte_results
    function automatic void predict_rx_byte(input logic [7:0] b, input logic [23:0] gap,
                                            input logic ovr);
        logic [7:0]  span;
        logic [7:0]  ty;
        logic [7:0]  len;
        logic [7:0]  crc;
        logic [7:0]  pb;
        logic [10:0] v;
        int unsigned n;
        int unsigned bitpos;
        byte_results.delete();
        if (ovr || gap > gap_lim)
            frame_pos = 8'd0;
        span = (frame_pos < 3) ? HEAD_LEN : mem_rd(1) + 8'd2;
        if (frame_pos >= span)
            return;
        if (frame_pos == 8'd0)
            frame_big = 1'b0;
        if (frame_pos < STORE_BYTES)
            frame_mem[frame_pos] = b;
        else
            frame_big = 1'b1;
        frame_pos = frame_pos + 8'd1;
        if (frame_pos < span)
            return;
        frame_pos = 8'd0;
        ty = mem_rd(2);
        if (frame_big)
        begin
            byte_results.push_back('{ST_OVERSIZE, ty, 4'd0, 11'd0, 1'b1});
            return;
        end
        if (ty != RC_TYPE)
        begin
            byte_results.push_back('{ST_OTHER_TYPE, ty, 4'd0, 11'd0, 1'b1});
            return;
        end
        len = mem_rd(1);
        crc = crc8_d5(8'h00, ty);
        n = (len >= 2) ? len - 2 : 0;
        for (int unsigned i = 0; i < n; i++)
            crc = crc8_d5(crc, mem_rd(PAYLOAD_AT + i));
        if (crc != mem_rd(PAYLOAD_AT + CRC_AT))
        begin
            byte_results.push_back('{ST_CRC_ERR, ty, 4'd0, 11'd0, 1'b1});
            return;
        end
        // lsb-first 11-bit channels
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            v = 11'd0;
            for (int k = 0; k < CH_BITS; k++)
            begin
                bitpos = CH_BITS * ch + k;
                pb = mem_rd(PAYLOAD_AT + bitpos / 8);
                v[k] = pb[bitpos % 8];
            end
            byte_results.push_back('{ST_CHANNEL, ty, 4'(ch), v, ch == CHANNELS - 1});
        end
    endfunction

    // offer one byte, record what it should cause, then maybe idle
    task automatic send_byte(input rx_row_t row);
        s_axis_tdata  <= {row.gap, row.rx};
        s_axis_tuser  <= row.ovr;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_in++;
        predict_rx_byte(row.rx, row.gap, row.ovr);
        if (row.chk == BY_TABLE)
        begin
            if (row.yields)
                pending_results.push_back('{row.st, row.ty, 4'd0, 11'd0, 1'b1});
        end
        else
        begin
            foreach (byte_results[i])
                pending_results.push_back(byte_results[i]);
        end
        // sender idle bursts
        if (!quiet && tx_calm == 0 && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
            tx_calm = $urandom_range(0, 30);
        end
        else if (tx_calm > 0)
        begin
            tx_calm--;
        end
    endtask

    // gap and overrun for a byte that starts a new frame
    task automatic frame_start_gap(output logic [23:0] gap, output logic ovr);
        if (gap_lim == 24'hFFFFFF || $urandom_range(0, 2) == 0)
        begin
            ovr = 1'b1;
            gap = 24'($urandom);
        end
        else
        begin
            ovr = 1'b0;
            gap = 24'($urandom_range(int'(gap_lim) + 1, 24'hFFFFFF));
        end
    endtask

    // gap for a byte inside a frame, never over the limit
    function automatic logic [23:0] in_frame_gap();
        int unsigned cap;
        cap = (gap_lim < 3000) ? gap_lim : 3000;
        if ($urandom_range(0, 3) == 0)
            return gap_lim;
        return 24'($urandom_range(0, cap));
    endfunction

    // build a byte sequence of the given kind and send it
    task automatic send_frame(input frame_kind_e kind);
        logic [7:0]  fb[$];
        logic [7:0]  crc;
        logic [7:0]  p;
        logic [7:0]  ty;
        int          len;
        int          fill;
        int          count;
        rx_row_t     row;
        fill = $urandom_range(0, 3);
        case (kind)
            FR_RC_GOOD, FR_RC_BAD_CRC:
            begin
                fb = {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hC8, 8'd24, RC_TYPE};
                crc = crc8_d5(8'h00, RC_TYPE);
                for (int i = 0; i < 22; i++)
                begin
                    p = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
                    fb.push_back(p);
                    crc = crc8_d5(crc, p);
                end
                if (kind == FR_RC_BAD_CRC)
                    crc = crc ^ 8'($urandom_range(1, 255));
                fb.push_back(crc);
            end
            FR_RC_ODD_LEN:
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(254, 255)
                                                  : $urandom_range(0, 40);
                count = (len <= 1 || len >= 254) ? 6 : len + 2;
                fb = {8'hC8, 8'(len), RC_TYPE};
                while (fb.size() < count)
                    fb.push_back(8'($urandom));
            end
            FR_OTHER, FR_OVERSIZE:
            begin
                ty = 8'($urandom);
                if (kind == FR_OVERSIZE && $urandom_range(0, 1) == 0)
                    ty = RC_TYPE;
                else if (ty == RC_TYPE)
                    ty = ty ^ 8'h01;
                len = (kind == FR_OVERSIZE) ? $urandom_range(63, 90) : $urandom_range(2, 30);
                fb = {8'hC8, 8'(len), ty};
                while (fb.size() < len + 2)
                    fb.push_back(8'($urandom));
            end
            default:
            begin
                // noise: random bytes with arbitrary gaps and overruns
                repeat ($urandom_range(1, 6))
                begin
                    row = '{8'($urandom), 24'($urandom), $urandom_range(0, 3) == 0,
                            BY_MODEL, 1'b0, ST_CHANNEL, 8'h00};
                    send_byte(row);
                end
            end
        endcase
        foreach (fb[i])
        begin
            row = '{fb[i], 24'd0, 1'b0, BY_MODEL, 1'b0, ST_CHANNEL, 8'h00};
            // an occasional restart breaks a frame in the middle
            if (i == 0 || $urandom_range(0, 59) == 0)
                frame_start_gap(row.gap, row.ovr);
            else
                row.gap = in_frame_gap();
            send_byte(row);
        end
    endtask

    // stop offering and let the block drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap_limit(input logic [23:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gap_lim = v;
    endtask

    // compare one output transaction with the oldest expectation
    task automatic check_result();
        rc_result_t got;
        rc_result_t want;
        string      got_s;
        string      want_s;
        got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tdata[22:12],
                m_axis_tlast};
        got_s = $sformatf("st=%0d ty=%h ch=%0d val=%0d last=%b",
                          got.status, got.ftype, got.idx, got.val, got.last);
        results_seen++;
        if (pending_results.size() == 0)
        begin
            err_count++;
            $display("%0t unexpected result: expected none, got %s", $time, got_s);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got !== want)
            begin
                err_count++;
                want_s = $sformatf("st=%0d ty=%h ch=%0d val=%0d last=%b",
                                   want.status, want.ftype, want.idx, want.val, want.last);
                $display("%0t mismatch: expected %s, got %s", $time, want_s, got_s);
            end
        end
    endtask

    // result side: checking, stall bursts and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (!holdoff_done && results_seen >= 8)
            begin
                holdoff_done = 1'b1;
                rx_hold = HOLDOFF_CYCLES;
            end
            else if (rx_hold == 0 && !quiet && rx_calm == 0 && $urandom_range(0, 4) == 0)
            begin
                rx_hold = $urandom_range(1, 17);
                rx_calm = $urandom_range(0, 30);
            end
            else if (rx_hold == 0 && rx_calm > 0)
            begin
                rx_calm--;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL crsf_frame_receiver_top");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [23:0] limits [4];
        int          phase_start;
        int          nframe;
        int          pick;
        frame_kind_e kind;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 24'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        err_count     = 0;
        bytes_in      = 0;
        results_seen  = 0;
        tx_calm       = 0;
        rx_calm       = 0;
        rx_hold       = 0;
        quiet         = 1'b0;
        holdoff_done  = 1'b0;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;
        frame_pos = 8'd0;
        frame_big = 1'b0;
        gap_lim   = GAP_LIMIT_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bytes
        foreach (dir_rows[i])
            send_byte(dir_rows[i]);

        // random frames under several gap limits, extremes first
        limits = '{24'hFFFFFF, 24'd0, 24'($urandom_range(1, 5000)), GAP_LIMIT_RESET};
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            write_gap_limit(limits[ph]);
            quiet = (ph == 3);
            phase_start = bytes_in;
            nframe = 0;
            while (bytes_in - phase_start < BYTES_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (nframe == 0)
                    kind = FR_RC_GOOD;
                else if (ph == 1 && nframe == 1)
                    kind = FR_OVERSIZE;
                else if (pick < 35)
                    kind = FR_RC_GOOD;
                else if (pick < 50)
                    kind = FR_RC_BAD_CRC;
                else if (pick < 62)
                    kind = FR_RC_ODD_LEN;
                else if (pick < 82)
                    kind = FR_OTHER;
                else if (pick < 86)
                    kind = FR_OVERSIZE;
                else
                    kind = FR_NOISE;
                send_frame(kind);
                nframe++;
            end
        end

        wait_idle();
        if (err_count == 0 && pending_results.size() == 0)
            $display("PASS crsf_frame_receiver_top");
        else
            $display("FAIL crsf_frame_receiver_top");
        $finish;
    end

endmodule
